FILE: src/jls_pkg.sv
// Jacobi solver package: item types, command codes, sizes, a saturation helper.
// No dependencies.
package jls_pkg;
	localparam int MaxUnknowns  = 16;
	localparam int IdxW         = $clog2(MaxUnknowns);
	localparam int FractionBits = 16;

	typedef enum logic [1:0] {
		CMD_LOAD_COEF = 2'd0,
		CMD_LOAD_RHS  = 2'd1,
		CMD_SOLVE     = 2'd2,
		CMD_NONE      = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_SYSTEM_SIZE    = 2'd0,
		REG_TOLERANCE      = 2'd1,
		REG_MAX_ITERATIONS = 2'd2,
		REG_UNUSED         = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_ROW, ST_MAC, ST_DIV, ST_ALIGN, ST_CHECK, ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [3:0]         row_index;
		logic [3:0]         col_index;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [3:0]         unknown_index;
		logic signed [31:0] unknown_value;
		logic               converged;
		logic               divide_fault;
		logic               last_unknown;
	} out_item_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage

FILE: src/jls_cell.sv
// One cell of the x shift ring: holds x_old[k] and x_new[k], rotates while shift is high.
// Depends on jls_pkg.
module jls_cell
	import jls_pkg::*;
(
	input  logic               clk,
	input  logic               shift,
	input  logic               clear,
	input  logic               commit,
	input  logic signed [31:0] old_in,
	input  logic signed [31:0] new_in,
	output logic signed [31:0] old_q,
	output logic signed [31:0] new_q
);
	always_ff @(posedge clk) begin
		if (clear) begin
			old_q <= '0;
			new_q <= '0;
		end else if (commit) begin
			old_q <= new_q;
		end else if (shift) begin
			old_q <= old_in;
			new_q <= new_in;
		end
	end
endmodule

FILE: src/jls_div.sv
// Restoring signed divider, one quotient bit per cycle: (num << F) / den.
// Depends on jls_pkg.
module jls_div
	import jls_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	output logic               done,
	output logic signed [31:0] quo
);
	localparam int NW = 32 + FractionBits;
	logic [NW-1:0]     n_q;
	logic [NW-1:0]     q_q;
	logic [32:0]       r_q;
	logic [31:0]       d_q;
	logic              neg_q;
	logic              busy_q;
	logic [6:0]        cnt_q;
	logic [33:0]       trial;
	logic signed [65:0] res;

	assign trial = {r_q, n_q[NW-1]} - {2'b0, d_q};
	always_comb begin
		res  = neg_q ? -$signed({18'd0, q_q}) : $signed({18'd0, q_q});
		quo  = sat32(res);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= {(num[31] ? 32'(-num) : 32'(num)), FractionBits'(0)};
			d_q   <= den[31] ? 32'(-den) : 32'(den);
			neg_q <= num[31] ^ den[31];
			r_q   <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			n_q <= n_q << 1;
			if (!trial[33]) begin
				r_q <= trial[32:0];
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= {r_q[31:0], n_q[NW-1]};
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule

FILE: src/jacobi_linear_solver_unit.sv
// Jacobi linear solver top: command decode, coefficient memory, MAC, cell ring.
// Depends on jls_pkg, jls_cell, jls_div.
//
//  channel | handshake         | payload
//  in      | start / busy      | in_item (in_item_t)
//  cfg     | cfg_we            | cfg_index, cfg_data
//  out     | result_valid      | result (out_item_t)
// Each load is written as it is accepted. A solve iteration runs, per row: a setup state,
// the MAC walk (all 16 ring cells, one coefficient memory read a cycle, then a drain)
// and the divider; after the last row, the ring is turned back round, then a check
// state. Results then leave one per cycle.
// busy is high from the solve item until the last result is registered.
// Reset clears the coefficient store by valid bits and the right-hand side directly.
// The receiver cannot stall; results are never held.
module jacobi_linear_solver_unit
	import jls_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_item_t    in_item,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        result_valid,
	output out_item_t   result
);
	localparam int N = MaxUnknowns;

	logic [4:0]  size_q;
	logic [15:0] tol_q;
	logic [15:0] cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 5'd16;
			tol_q  <= '0;
			cap_q  <= 16'd1000;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SYSTEM_SIZE:    size_q <= cfg_data[4:0];
				REG_TOLERANCE:      tol_q  <= cfg_data;
				REG_MAX_ITERATIONS: cap_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic signed [31:0] coef_mem [N*N];
	logic [N*N-1:0]     coef_vld_q;
	logic signed [31:0] rhs_q [N];
	logic signed [31:0] coef_rd_s1;
	logic               coef_rv_s1;
	logic [7:0]         rd_addr;

	state_t state_q, state_d;
	logic [IdxW-1:0] row_q, col_q;
	logic [IdxW:0]   n_eff;
	logic [15:0]     iter_q;
	logic            fault_q, close_q, conv_q, diag_zero_q;
	logic signed [31:0] acc_q, diag_q;
	logic [IdxW:0]   step_q;
	logic            accept;
	logic            div_start, div_done;
	logic signed [31:0] quo;

	assign accept = start && !busy;
	assign n_eff  = (size_q == 5'd0) ? 5'd1 : (size_q > 5'(N) ? 5'(N) : size_q);

	always_ff @(posedge clk) begin
		if (accept && in_item.cmd == CMD_LOAD_COEF)
			coef_mem[{in_item.row_index, in_item.col_index}] <= in_item.value;
		coef_rd_s1 <= coef_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
			coef_rv_s1 <= 1'b0;
			for (int k = 0; k < N; k++) rhs_q[k] <= '0;
		end else begin
			coef_rv_s1 <= coef_vld_q[rd_addr];
			if (accept && in_item.cmd == CMD_LOAD_COEF)
				coef_vld_q[{in_item.row_index, in_item.col_index}] <= 1'b1;
			if (accept && in_item.cmd == CMD_LOAD_RHS)
				rhs_q[in_item.row_index] <= in_item.value;
		end
	end

	// ring of cells; cell 0 presents x[col] while rotating
	logic signed [31:0] old_c [N];
	logic signed [31:0] new_c [N];
	logic shift_en, clr_en, commit_en, ins_new;

	// diff check: as each new x is inserted compare with old of same cell
	logic signed [32:0] dlt;
	logic [32:0]        adlt;
	logic signed [31:0] newx;
	assign newx = diag_zero_q ? 32'sd0 : quo;
	assign dlt  = 33'(newx) - 33'(old_c[0]);
	assign adlt = dlt[32] ? 33'(-dlt) : 33'(dlt);

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_ring
			logic signed [31:0] oin, nin;
			always_comb begin
				oin = old_c[(g + 1) % N];
				nin = new_c[(g + 1) % N];
				if (g == N - 1) begin
					oin = old_c[0];
					nin = (ins_new) ? newx : new_c[0];
				end
			end
			jls_cell u_cell (
				.clk(clk), .shift(shift_en), .clear(clr_en), .commit(commit_en),
				.old_in(oin), .new_in(nin), .old_q(old_c[g]), .new_q(new_c[g])
			);
		end
	endgenerate

	// product and accumulate
	logic signed [63:0] prod;
	logic signed [31:0] q_s;
	logic signed [31:0] coef_use;
	logic               mac_s1;
	logic               skip_s1;
	logic signed [31:0] x_s1;
	assign coef_use = coef_rv_s1 ? coef_rd_s1 : 32'sd0;
	assign prod = 64'(coef_use) * 64'(x_s1);
	assign q_s  = sat32(66'(prod >>> FractionBits));

	assign rd_addr = {row_q, col_q};
	assign div_start = (state_q == ST_MAC) && !mac_s1 && (step_q == 5'(N) + 5'd1);

	// ring walks all N cells per row starting at the row's own column;
	// after the last row it turns the rest of the way round
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept && in_item.cmd == CMD_SOLVE) state_d = ST_ROW;
			ST_ROW:   state_d = ST_MAC;
			ST_MAC:   if (div_start) state_d = ST_DIV;
			ST_DIV:   if (div_done) state_d =
				(row_q == 4'(n_eff - 5'd1)) ? ST_ALIGN : ST_ROW;
			ST_ALIGN: if (step_q == 5'(N)) state_d = ST_CHECK;
			ST_CHECK: if (close_q || iter_q + 16'd1 >= ((cap_q == 0) ? 16'd1 : cap_q))
				state_d = ST_EMIT;
				else state_d = ST_ROW;
			ST_EMIT:  if (row_q == 4'(n_eff - 5'd1)) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy      = state_q != ST_IDLE;
		clr_en    = accept && in_item.cmd == CMD_SOLVE;
		shift_en  = (state_q == ST_MAC && step_q < 5'(N)) ||
			(state_q == ST_DIV && div_done) ||
			(state_q == ST_ALIGN && step_q != 5'(N)) || state_q == ST_EMIT;
		ins_new   = state_q == ST_DIV;
		commit_en = state_q == ST_CHECK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q <= '0; col_q <= '0; step_q <= '0; iter_q <= '0;
			fault_q <= 1'b0; close_q <= 1'b1; conv_q <= 1'b0;
			mac_s1 <= 1'b0; skip_s1 <= 1'b0; x_s1 <= '0;
			acc_q <= '0; diag_q <= '0; diag_zero_q <= 1'b0;
			result_valid <= 1'b0; result <= '0;
		end else begin
			state_q <= state_d;
			result_valid <= 1'b0;
			mac_s1 <= state_q == ST_MAC && step_q < 5'(N);
			skip_s1 <= (col_q == row_q) || (5'(col_q) >= n_eff);
			x_s1 <= old_c[0];
			unique case (state_q)
				ST_IDLE: if (clr_en) begin
					row_q <= '0; iter_q <= '0; fault_q <= 1'b0; close_q <= 1'b1;
				end
				ST_ROW: begin
					col_q <= row_q; step_q <= '0;
					acc_q <= rhs_q[row_q];
				end
				ST_MAC: begin
					if (step_q < 5'(N)) begin
						col_q  <= col_q + 4'd1;
					end
					if (step_q != 5'(N) + 5'd1) step_q <= step_q + 5'd1;
					if (mac_s1) begin
						if (skip_s1) begin
							if (col_q - 4'd1 == row_q) diag_q <= coef_use;
						end else acc_q <= sat32(66'(acc_q) - 66'(q_s));
					end
				end
				ST_DIV: begin
					diag_zero_q <= diag_q == 0;
					if (div_done) begin
						if (diag_q == 0) fault_q <= 1'b1;
						if (adlt > {17'd0, tol_q}) close_q <= 1'b0;
						row_q <= row_q + 4'd1;
						step_q <= n_eff;
					end
				end
				ST_ALIGN: begin
					if (step_q != 5'(N)) step_q <= step_q + 5'd1;
				end
				ST_CHECK: begin
					iter_q <= iter_q + 16'd1;
					row_q <= '0;
					conv_q <= close_q;
					if (state_d == ST_ROW) close_q <= 1'b1;
				end
				ST_EMIT: begin
					result_valid <= 1'b1;
					result.unknown_index <= row_q;
					result.unknown_value <= new_c[0];
					result.converged <= conv_q;
					result.divide_fault <= fault_q;
					result.last_unknown <= row_q == 4'(n_eff - 5'd1);
					row_q <= row_q + 4'd1;
				end
				default: ;
			endcase
		end
	end

	logic signed [31:0] div_num;
	assign div_num = acc_q;
	jls_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(div_num), .den((diag_q == 0) ? 32'sd1 : diag_q),
		.done(div_done), .quo(quo)
	);
endmodule
